>>> hdl/lcg_ranged_random_defines.svh
// assertion macros for the ranged random generator
`ifndef LCG_RANGED_RANDOM_DEFINES_SVH
`define LCG_RANGED_RANDOM_DEFINES_SVH
`ifndef ASSERT_OFF
`define LRR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrr assertion failed");
`define LRR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrr assertion failed");
`else
`define LRR_ASSERT_IMP(label, clk, rst, ante, cons)
`define LRR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/lrr_pkg.sv
// types and constants shared by the ranged random generator
package lrr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned MOD_W  = 33;
  localparam int unsigned NUM_W  = 56;
  localparam int unsigned STEP_W = 6;
  localparam int unsigned ADDR_W = 4;

  localparam logic [STEP_W-1:0] STEPS_32   = 6'd32;
  localparam logic [STEP_W-1:0] STEPS_33   = 6'd33;
  localparam logic [STEP_W-1:0] STEPS_FRAC = 6'd56;

  localparam logic [DATA_W-1:0] RESET_MULT = 32'd1103515245;
  localparam logic [DATA_W-1:0] RESET_INC  = 32'd12345;
  localparam logic [DATA_W-1:0] RESET_MOD  = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_MULT = 2'd0,
    REG_INC  = 2'd1,
    REG_MOD  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_MOD  = 2'd0,
    OP_SPAN = 2'd1,
    OP_QUOT = 2'd2,
    OP_FRAC = 2'd3
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD_GO,
    ST_MOD_RUN,
    ST_SPAN_GO,
    ST_SPAN_RUN,
    ST_QUOT_GO,
    ST_QUOT_RUN,
    ST_FRAC_GO,
    ST_FRAC_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    start;
    logic    store;
    div_op_t op;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic range_error;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/lcg_ranged_random.sv
// top level of the ranged random generator: register port, controller, datapath
//
//  channel  | signals                      | direction
//  ---------+------------------------------+----------
//  s_*      | tvalid tready tdata tuser    | in: draw or reseed request
//  m_*      | tvalid tready tdata tuser    | out: state, ranged value, fraction
//  apb      | psel penable pwrite paddr .. | in: multiplier, increment, modulus
//
// one item at a time; each item runs the multiply, then the shared one-bit-per-cycle
// divider for modulus, span, quotient, fraction; empty range skips span and quotient
// s_tready is high only between items; a finished result waits in the output
// register, and the next transaction can be taken while it waits
// rst clears the state word, control and registers to their defaults
`include "lcg_ranged_random_defines.svh"
module lcg_ranged_random (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // seed, range_low, range_high
  input  logic                          s_tuser,   // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [87:0]                   m_tdata,   // raw, ranged, fraction
  output logic                          m_tuser,   // range_error
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrr_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [lrr_pkg::DATA_W-1:0] multiplier;
  logic [lrr_pkg::DATA_W-1:0] increment;
  logic [lrr_pkg::DATA_W-1:0] modulus;
  lrr_pkg::reg_idx_t          reg_idx;
  logic                       wr_en;

  lrr_pkg::dp_cmd_t           cmd;
  lrr_pkg::dp_status_t        status;

  logic [lrr_pkg::DATA_W-1:0] raw;
  logic [lrr_pkg::DATA_W-1:0] ranged;
  logic [lrr_pkg::FRAC_W-1:0] fraction;

  assign pready  = 1'b1;
  assign reg_idx = lrr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= lrr_pkg::RESET_MULT;
      increment  <= lrr_pkg::RESET_INC;
      modulus    <= lrr_pkg::RESET_MOD;
    end else if (wr_en) begin
      unique case (reg_idx)
        lrr_pkg::REG_MULT: multiplier <= pwdata;
        lrr_pkg::REG_INC:  increment  <= pwdata;
        lrr_pkg::REG_MOD:  modulus    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lrr_pkg::REG_MULT: prdata = multiplier;
      lrr_pkg::REG_INC:  prdata = increment;
      lrr_pkg::REG_MOD:  prdata = modulus;
      default:           prdata = '0;
    endcase
  end

  lrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lrr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .action      (s_tuser),
    .seed        (s_tdata[31:0]),
    .range_low   (s_tdata[63:32]),
    .range_high  (s_tdata[95:64]),
    .multiplier  (multiplier),
    .increment   (increment),
    .modulus     (modulus),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .raw         (raw),
    .ranged      (ranged),
    .fraction    (fraction),
    .range_error (m_tuser)
  );

  assign m_tdata = {fraction, ranged, raw};

  `LRR_ASSERT_NXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)
  `LRR_ASSERT_IMP(a_store_on_done, clk, rst, cmd.store, status.div_done)
  `LRR_ASSERT_NXT(a_div_not_instant, clk, rst, cmd.start, !cmd.start && !status.div_done)

endmodule

>>> hdl/lrr_div.sv
// restoring divider, one quotient bit per cycle, dividend left aligned
module lrr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lrr_pkg::NUM_W-1:0]    dividend,
  input  logic [lrr_pkg::MOD_W-1:0]    divisor,
  input  logic [lrr_pkg::STEP_W-1:0]   steps,
  output logic                         done,
  output logic [lrr_pkg::MOD_W-1:0]    quotient,
  output logic [lrr_pkg::MOD_W-1:0]    remainder
);

  logic                          busy;
  logic [lrr_pkg::STEP_W-1:0]    cnt;
  logic [lrr_pkg::NUM_W-1:0]     num;
  logic [lrr_pkg::MOD_W-1:0]     dsr;
  logic [lrr_pkg::MOD_W:0]       trial;
  logic [lrr_pkg::MOD_W:0]       diff;
  logic                          fits;

  assign trial = {remainder, num[lrr_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == lrr_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
      quotient  <= '0;
    end else if (busy) begin
      num <= {num[lrr_pkg::NUM_W-2:0], 1'b0};
      if (fits) begin
        remainder <= diff[lrr_pkg::MOD_W-1:0];
        quotient  <= {quotient[lrr_pkg::MOD_W-2:0], 1'b1};
      end else begin
        remainder <= trial[lrr_pkg::MOD_W-1:0];
        quotient  <= {quotient[lrr_pkg::MOD_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/lrr_dp.sv
// datapath: item registers, multiplier, shared divider and output register
module lrr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lrr_pkg::dp_cmd_t              cmd,
  output lrr_pkg::dp_status_t           status,
  input  logic                          action,
  input  logic [lrr_pkg::DATA_W-1:0]    seed,
  input  logic [lrr_pkg::DATA_W-1:0]    range_low,
  input  logic [lrr_pkg::DATA_W-1:0]    range_high,
  input  logic [lrr_pkg::DATA_W-1:0]    multiplier,
  input  logic [lrr_pkg::DATA_W-1:0]    increment,
  input  logic [lrr_pkg::DATA_W-1:0]    modulus,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lrr_pkg::DATA_W-1:0]    raw,
  output logic [lrr_pkg::DATA_W-1:0]    ranged,
  output logic [lrr_pkg::FRAC_W-1:0]    fraction,
  output logic                          range_error
);

  logic [lrr_pkg::DATA_W-1:0]   x;
  logic [lrr_pkg::DATA_W-1:0]   lo;
  logic [lrr_pkg::DATA_W-1:0]   hi;
  logic                         err;
  logic [lrr_pkg::DATA_W-1:0]   prod;
  logic [lrr_pkg::DATA_W-1:0]   current;
  logic [lrr_pkg::MOD_W-1:0]    step_div;
  logic [lrr_pkg::DATA_W-1:0]   rng;
  logic [lrr_pkg::FRAC_W-1:0]   frac;

  logic [2*lrr_pkg::DATA_W-1:0] full_prod;
  logic [lrr_pkg::DATA_W-1:0]   wrapped;
  logic [lrr_pkg::MOD_W-1:0]    mod_eff;
  logic [lrr_pkg::DATA_W-1:0]   span;

  logic [lrr_pkg::NUM_W-1:0]    div_num;
  logic [lrr_pkg::MOD_W-1:0]    div_den;
  logic [lrr_pkg::STEP_W-1:0]   div_steps;
  logic                         div_done;
  logic [lrr_pkg::MOD_W-1:0]    div_quo;
  logic [lrr_pkg::MOD_W-1:0]    div_rem;

  assign full_prod = multiplier * x;
  assign wrapped   = prod + increment;
  // a zero modulus stands for 2^32
  assign mod_eff   = {modulus == '0, modulus};
  assign span      = hi - lo;

  always_comb begin
    case (cmd.op)
      lrr_pkg::OP_MOD: begin
        div_num   = {wrapped, {lrr_pkg::FRAC_W{1'b0}}};
        div_den   = mod_eff;
        div_steps = lrr_pkg::STEPS_32;
      end
      lrr_pkg::OP_SPAN: begin
        div_num   = {mod_eff, {(lrr_pkg::NUM_W-lrr_pkg::MOD_W){1'b0}}};
        div_den   = {1'b0, span};
        div_steps = lrr_pkg::STEPS_33;
      end
      lrr_pkg::OP_QUOT: begin
        div_num   = {current, {lrr_pkg::FRAC_W{1'b0}}};
        div_den   = step_div;
        div_steps = lrr_pkg::STEPS_32;
      end
      default: begin
        div_num   = {current, {lrr_pkg::FRAC_W{1'b0}}};
        div_den   = mod_eff;
        div_steps = lrr_pkg::STEPS_FRAC;
      end
    endcase
  end

  lrr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start),
    .dividend  (div_num),
    .divisor   (div_den),
    .steps     (div_steps),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      current <= '0;
    end else if (cmd.store && cmd.op == lrr_pkg::OP_MOD) begin
      current <= div_rem[lrr_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= action ? seed : current;
      lo  <= range_low;
      hi  <= range_high;
      err <= range_high <= range_low;
      rng <= range_low;
    end
    if (cmd.mul) begin
      prod <= full_prod[lrr_pkg::DATA_W-1:0];
    end
    if (cmd.store) begin
      case (cmd.op)
        lrr_pkg::OP_SPAN: step_div <= div_quo + lrr_pkg::MOD_W'(1);
        lrr_pkg::OP_QUOT: rng      <= lo + div_quo[lrr_pkg::DATA_W-1:0];
        lrr_pkg::OP_FRAC: frac     <= div_quo[lrr_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw         <= current;
      ranged      <= rng;
      fraction    <= frac;
      range_error <= err;
    end
  end

  assign status.div_done    = div_done;
  assign status.range_error = err;
  assign status.out_free    = !out_valid || out_ready;

endmodule

>>> hdl/lrr_ctrl.sv
// controller: sequences multiply and the four divisions of one item, two of them skipped for an empty range
module lrr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output lrr_pkg::dp_cmd_t     cmd,
  input  lrr_pkg::dp_status_t  status
);

  lrr_pkg::state_t state;
  lrr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.op       = lrr_pkg::OP_MOD;
    unique case (state)
      lrr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lrr_pkg::ST_MUL;
        end
      end
      lrr_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = lrr_pkg::ST_MOD_GO;
      end
      lrr_pkg::ST_MOD_GO: begin
        cmd.start  = 1'b1;
        state_next = lrr_pkg::ST_MOD_RUN;
      end
      lrr_pkg::ST_MOD_RUN: begin
        if (status.div_done) begin
          cmd.store  = 1'b1;
          // empty range skips both range divisions
          state_next = status.range_error ? lrr_pkg::ST_FRAC_GO : lrr_pkg::ST_SPAN_GO;
        end
      end
      lrr_pkg::ST_SPAN_GO: begin
        cmd.op     = lrr_pkg::OP_SPAN;
        cmd.start  = 1'b1;
        state_next = lrr_pkg::ST_SPAN_RUN;
      end
      lrr_pkg::ST_SPAN_RUN: begin
        cmd.op = lrr_pkg::OP_SPAN;
        if (status.div_done) begin
          cmd.store  = 1'b1;
          state_next = lrr_pkg::ST_QUOT_GO;
        end
      end
      lrr_pkg::ST_QUOT_GO: begin
        cmd.op     = lrr_pkg::OP_QUOT;
        cmd.start  = 1'b1;
        state_next = lrr_pkg::ST_QUOT_RUN;
      end
      lrr_pkg::ST_QUOT_RUN: begin
        cmd.op = lrr_pkg::OP_QUOT;
        if (status.div_done) begin
          cmd.store  = 1'b1;
          state_next = lrr_pkg::ST_FRAC_GO;
        end
      end
      lrr_pkg::ST_FRAC_GO: begin
        cmd.op     = lrr_pkg::OP_FRAC;
        cmd.start  = 1'b1;
        state_next = lrr_pkg::ST_FRAC_RUN;
      end
      lrr_pkg::ST_FRAC_RUN: begin
        cmd.op = lrr_pkg::OP_FRAC;
        if (status.div_done) begin
          cmd.store  = 1'b1;
          state_next = lrr_pkg::ST_DONE;
        end
      end
      lrr_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = lrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lrr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
